// ===== rtl/core/fps_pkg.sv =====
package fps_pkg;

   // Ring of earlier pressure samples
   localparam int RING_DEPTH = 8;
   localparam int PRESSURE_W = 17;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int SUM_W      = PRESSURE_W + IDX_W;

   // Field widths
   localparam int ALT_W      = 21;
   localparam int ACCEL_W    = 16;
   localparam int CMD_W      = 3;
   localparam int PHASE_W    = 3;
   localparam int PULSE_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   // Servo pulse widths in microseconds
   localparam logic [PULSE_W-1:0] PULSE_CLOSED = 13'd1000;
   localparam logic [PULSE_W-1:0] PULSE_OPEN   = 13'd5000;

   // Register reset values
   localparam logic signed [ACCEL_W-1:0] LAUNCH_RST  = 16'sd3000;
   localparam logic signed [ACCEL_W-1:0] BURNOUT_RST = 16'sd0;
   localparam logic signed [ALT_W-1:0]   MAIN_RST    = 21'sd3000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAUNCH_ACCEL  = 2'd0,
      CSR_BURNOUT_ACCEL = 2'd1,
      CSR_MAIN_ALT      = 2'd2
   } csr_index_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_PRELAUNCH = 3'd0,
      PH_READY     = 3'd1,
      PH_POWERED   = 3'd2,
      PH_UNPOWERED = 3'd3,
      PH_DROGUE    = 3'd4,
      PH_MAIN      = 3'd5,
      PH_TEST      = 3'd6,
      PH_END       = 3'd7
   } phase_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE   = 3'd0,
      CMD_LAUNCH = 3'd1,
      CMD_TEST   = 3'd2,
      CMD_END    = 3'd3,
      CMD_PRE    = 3'd4,
      CMD_DROGUE = 3'd5,
      CMD_MAINSH = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] launch_accel;
      logic signed [ACCEL_W-1:0] burnout_accel;
      logic signed [ALT_W-1:0]   main_alt;
   } cfg_type;

   // Sequencer controls for the ring unit
   typedef struct packed {
      logic start;
      logic add;
      logic write;
   } ring_ctl_type;

   typedef struct packed {
      logic                 done;
      logic                 descending;
   } ring_sts_type;

   typedef struct packed {
      phase_type            phase;
      logic                 servo_update;
      logic [PULSE_W-1:0]   servo_pulse_us;
      logic                 command_consumed;
   } result_type;

endpackage

// ===== rtl/core/fps_ring.sv =====
module fps_ring (
   input  logic                              clock,
   input  logic                              reset,
   input  fps_pkg::ring_ctl_type             ctl,
   input  logic [fps_pkg::PRESSURE_W-1:0]    pressure,
   output fps_pkg::ring_sts_type             sts
);
   import fps_pkg::*;

   logic [PRESSURE_W-1:0] ring_ff [RING_DEPTH];
   logic [IDX_W-1:0]      ptr_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [SUM_W-1:0]      acc_ff;
   logic [SUM_W-1:0]      acc_in;
   logic [SUM_W-1:0]      scaled;

   // Shared adder: one ring entry per cycle
   assign acc_in = acc_ff + SUM_W'(ring_ff[cnt_ff[IDX_W-1:0]]);

   // Mean compare without division: sum < pressure * depth
   assign scaled = SUM_W'(pressure) * SUM_W'(RING_DEPTH);

   assign sts.done       = (cnt_ff == CNT_W'(RING_DEPTH));
   assign sts.descending = (acc_ff < scaled);

   // Accumulate over the ring
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         acc_ff <= '0;
      end else if (ctl.start) begin
         cnt_ff <= '0;
         acc_ff <= '0;
      end else if (ctl.add) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         acc_ff <= acc_in;
      end
   end

   // Overwrite the oldest sample and advance the pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (ctl.write) begin
         ring_ff[ptr_ff] <= pressure;
         if (ptr_ff == IDX_W'(RING_DEPTH - 1)) begin
            ptr_ff <= '0;
         end else begin
            ptr_ff <= ptr_ff + IDX_W'(1);
         end
      end
   end

endmodule

// ===== rtl/core/fps_phase.sv =====
module fps_phase (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  fps_pkg::cfg_type                  cfg,
   input  logic [fps_pkg::CMD_W-1:0]         command,
   input  logic signed [fps_pkg::ALT_W-1:0]  altitude,
   input  logic signed [fps_pkg::ACCEL_W-1:0] accel,
   input  logic                              descending,
   output fps_pkg::result_type               result
);
   import fps_pkg::*;

   phase_type          phase_ff;
   phase_type          phase_in;
   logic [CMD_W-1:0]   pend_ff;
   logic [CMD_W-1:0]   pend_in;
   cmd_type            pend_eff;
   logic               consumed;
   logic [PULSE_W-1:0] pulse;

   // A new command replaces the pending one before the phase check
   assign pend_eff = (command != CMD_W'(CMD_NONE)) ? cmd_type'(command) : cmd_type'(pend_ff);

   // Phase transition
   always_comb begin
      phase_in = phase_ff;
      consumed = 1'b0;
      pulse    = '0;
      unique case (phase_ff)
         PH_PRELAUNCH: begin
            priority if (pend_eff == CMD_LAUNCH) begin
               pulse = PULSE_CLOSED; phase_in = PH_READY; consumed = 1'b1;
            end else if (pend_eff == CMD_TEST) begin
               pulse = PULSE_CLOSED; phase_in = PH_TEST; consumed = 1'b1;
            end else if (pend_eff == CMD_END) begin
               phase_in = PH_END; consumed = 1'b1;
            end else begin
            end
         end
         PH_READY: begin
            priority if (pend_eff == CMD_PRE) begin
               phase_in = PH_PRELAUNCH; consumed = 1'b1;
            end else if (pend_eff == CMD_TEST) begin
               phase_in = PH_TEST; consumed = 1'b1;
            end else if (pend_eff == CMD_END) begin
               phase_in = PH_END; consumed = 1'b1;
            end else if (accel > cfg.launch_accel) begin
               phase_in = PH_POWERED;
            end else begin
            end
         end
         PH_POWERED: begin
            if (accel < cfg.burnout_accel) begin
               phase_in = PH_UNPOWERED;
            end
         end
         PH_UNPOWERED: begin
            if (descending) begin
               phase_in = PH_DROGUE;
            end
         end
         PH_DROGUE: begin
            priority if (altitude < cfg.main_alt) begin
               phase_in = PH_MAIN;
            end else if (pend_eff == CMD_END) begin
               phase_in = PH_END; consumed = 1'b1;
            end else begin
            end
         end
         PH_MAIN: begin
            // Ascent again ends the flight without taking the command
            priority if (!descending) begin
               phase_in = PH_END;
            end else if (pend_eff == CMD_END) begin
               phase_in = PH_END; consumed = 1'b1;
            end else begin
            end
         end
         PH_TEST: begin
            priority if (pend_eff == CMD_DROGUE) begin
               pulse = PULSE_OPEN; phase_in = PH_DROGUE; consumed = 1'b1;
            end else if (pend_eff == CMD_MAINSH) begin
               phase_in = PH_MAIN; consumed = 1'b1;
            end else if (pend_eff == CMD_END) begin
               phase_in = PH_END; consumed = 1'b1;
            end else begin
            end
         end
         PH_END: begin
            if (pend_eff == CMD_PRE) begin
               phase_in = PH_PRELAUNCH; consumed = 1'b1;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Clear the pending command once a transition takes it
   assign pend_in = consumed ? CMD_W'(CMD_NONE) : CMD_W'(pend_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PRELAUNCH;
         pend_ff  <= CMD_W'(CMD_NONE);
      end else if (step) begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
      end
   end

   assign result.phase            = phase_in;
   assign result.servo_update     = (pulse != '0);
   assign result.servo_pulse_us   = pulse;
   assign result.command_consumed = consumed;

endmodule

// ===== rtl/core/flight_phase_sequencer_top.sv =====
// Channel   Direction  Handshake          Word
// req_      in         valid / stall      pressure, altitude, accel, command
// rsp_      out        valid / stall      phase, descent flag, servo, consumed flag
// csr_      in         valid / ready      register index, write data
//
// An accepted sample is captured, the ring sum is run through the single adder,
// then the compare step advances the phase and loads the result word.
// The result register holds a word while rsp_stall is high; a new sample is
// taken meanwhile and waits in the compare step until that word leaves.
// Synchronous reset clears the ring, pointer, phase and pending command, and
// loads the config registers with their reset values; csr_ready is always high.
module flight_phase_sequencer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [fps_pkg::PRESSURE_W-1:0]       req_pressure_pa,
   input  logic signed [fps_pkg::ALT_W-1:0]     req_altitude_dm,
   input  logic signed [fps_pkg::ACCEL_W-1:0]   req_accel_z,
   input  logic [fps_pkg::CMD_W-1:0]            req_command,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fps_pkg::PHASE_W-1:0]          rsp_phase,
   output logic                                 rsp_descending,
   output logic                                 rsp_servo_update,
   output logic [fps_pkg::PULSE_W-1:0]          rsp_servo_pulse_us,
   output logic                                 rsp_command_consumed,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fps_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import fps_pkg::*;

   state_type                  state_ff;
   state_type                  state_in;
   cfg_type                    cfg_ff;
   ring_ctl_type               ring_ctl;
   ring_sts_type               ring_sts;
   result_type                 result;
   logic                       accept;
   logic                       load;
   logic                       out_busy;

   logic [PRESSURE_W-1:0]      pres_ff;
   logic signed [ALT_W-1:0]    alt_ff;
   logic signed [ACCEL_W-1:0]  accel_ff;
   logic [CMD_W-1:0]           cmd_ff;

   logic                       rsp_valid_ff;
   logic [PHASE_W-1:0]         rsp_phase_ff;
   logic                       rsp_desc_ff;
   logic                       rsp_servo_ff;
   logic [PULSE_W-1:0]         rsp_pulse_ff;
   logic                       rsp_consumed_ff;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.launch_accel  <= LAUNCH_RST;
         cfg_ff.burnout_accel <= BURNOUT_RST;
         cfg_ff.main_alt      <= MAIN_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LAUNCH_ACCEL:  cfg_ff.launch_accel  <= csr_wdata[ACCEL_W-1:0];
            CSR_BURNOUT_ACCEL: cfg_ff.burnout_accel <= csr_wdata[ACCEL_W-1:0];
            CSR_MAIN_ALT:      cfg_ff.main_alt      <= csr_wdata[ALT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the input word
   always_ff @(posedge clock) begin
      if (accept) begin
         pres_ff  <= req_pressure_pa;
         alt_ff   <= req_altitude_dm;
         accel_ff <= req_accel_z;
         cmd_ff   <= req_command;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept)        state_in = ST_SUM;
         ST_SUM:    if (ring_sts.done) state_in = ST_DECIDE;
         ST_DECIDE: if (!out_busy)     state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ring_ctl.start = 1'b0;
      ring_ctl.add   = 1'b0;
      ring_ctl.write = 1'b0;
      load           = 1'b0;
      unique case (state_ff)
         ST_IDLE:   ring_ctl.start = accept;
         ST_SUM:    ring_ctl.add   = !ring_sts.done;
         ST_DECIDE: begin
            ring_ctl.write = !out_busy;
            load           = !out_busy;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   fps_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ring_ctl),
      .pressure (pres_ff),
      .sts      (ring_sts)
   );

   fps_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .step       (load),
      .cfg        (cfg_ff),
      .command    (cmd_ff),
      .altitude   (alt_ff),
      .accel      (accel_ff),
      .descending (ring_sts.descending),
      .result     (result)
   );

   // Result register: load on decide, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_phase_ff    <= result.phase;
         rsp_desc_ff     <= ring_sts.descending;
         rsp_servo_ff    <= result.servo_update;
         rsp_pulse_ff    <= result.servo_pulse_us;
         rsp_consumed_ff <= result.command_consumed;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_phase            = rsp_phase_ff;
   assign rsp_descending       = rsp_desc_ff;
   assign rsp_servo_update     = rsp_servo_ff;
   assign rsp_servo_pulse_us   = rsp_pulse_ff;
   assign rsp_command_consumed = rsp_consumed_ff;

   // An accepted word always starts the ring sum
   a_accept_sum: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SUM))
      else $error("accepted word did not start the ring sum");

   // The compare step is reached only with the full ring summed
   a_decide_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> ring_sts.done)
      else $error("compare reached before ring sum finished");

   // Servo flag and pulse width agree
   a_servo_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_servo_update == (rsp_servo_pulse_us != '0)))
      else $error("servo flag and pulse width disagree");

   // Flight phases driven by sensors never consume a command
   a_consume_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command_consumed) |->
         (rsp_phase != PH_POWERED) && (rsp_phase != PH_UNPOWERED))
      else $error("command consumed on a sensor-driven transition");

endmodule

// ===== dv/flight_phase_sequencer_top_test.sv =====
`timescale 1ns / 1ps

import fps_pkg::*;

// One sample word as it goes into the sequencer
typedef struct {
   logic [PRESSURE_W-1:0]       pressure;
   logic signed [ALT_W-1:0]     altitude;
   logic signed [ACCEL_W-1:0]   accel;
   logic [CMD_W-1:0]            command;
} sample_word;

// One result word, laid out in port order so a concatenation of the ports fits
typedef struct packed {
   phase_type                   phase;
   logic                        descending;
   logic                        servo_update;
   logic [PULSE_W-1:0]          servo_pulse_us;
   logic                        command_consumed;
} flight_word;

class sequencer_scoreboard;
   logic signed [ACCEL_W-1:0]   launch_thr;
   logic signed [ACCEL_W-1:0]   burnout_thr;
   logic signed [ALT_W-1:0]     main_thr;
   phase_type                   phase;
   logic [PRESSURE_W-1:0]       ring [RING_DEPTH];
   int unsigned                 slot;
   logic [CMD_W-1:0]            held_cmd;
   flight_word                  expected_words[$];
   int                          mismatches;

   function new();
      launch_thr  = LAUNCH_RST;
      burnout_thr = BURNOUT_RST;
      main_thr    = MAIN_RST;
      phase       = PH_PRELAUNCH;
      foreach (ring[i]) ring[i] = '0;
      slot        = 0;
      held_cmd    = CMD_NONE;
      mismatches  = 0;
   endfunction

   // Mirror a register write; an unused index changes nothing
   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_LAUNCH_ACCEL: launch_thr = data[ACCEL_W-1:0];
         CSR_BURNOUT_ACCEL: burnout_thr = data[ACCEL_W-1:0];
         CSR_MAIN_ALT: main_thr = data;
         default: ;
      endcase
   endfunction

   function int unsigned ring_total();
      int unsigned total;
      total = 0;
      foreach (ring[i]) total += ring[i];
      return total;
   endfunction

   // Advance the flight phase for one accepted sample and queue its result word
   function void take_sample(sample_word s);
      flight_word w;
      phase_type  nxt;
      w = '0;
      // compare with the mean of earlier samples before the oldest is replaced
      w.descending = ring_total() < s.pressure * RING_DEPTH;
      ring[slot] = s.pressure;
      slot = (slot + 1) % RING_DEPTH;
      if (s.command != CMD_NONE) held_cmd = s.command;
      nxt = phase;
      case (phase)
         PH_PRELAUNCH: begin
            if (held_cmd == CMD_LAUNCH) begin
               w.servo_pulse_us = PULSE_CLOSED; nxt = PH_READY; w.command_consumed = 1'b1;
            end else if (held_cmd == CMD_TEST) begin
               w.servo_pulse_us = PULSE_CLOSED; nxt = PH_TEST; w.command_consumed = 1'b1;
            end else if (held_cmd == CMD_END) begin
               nxt = PH_END; w.command_consumed = 1'b1;
            end
         end
         PH_READY: begin
            if (held_cmd == CMD_PRE) begin
               nxt = PH_PRELAUNCH; w.command_consumed = 1'b1;
            end else if (held_cmd == CMD_TEST) begin
               nxt = PH_TEST; w.command_consumed = 1'b1;
            end else if (held_cmd == CMD_END) begin
               nxt = PH_END; w.command_consumed = 1'b1;
            end else if (s.accel > launch_thr) begin
               nxt = PH_POWERED;
            end
         end
         PH_POWERED: begin
            if (s.accel < burnout_thr) nxt = PH_UNPOWERED;
         end
         PH_UNPOWERED: begin
            if (w.descending) nxt = PH_DROGUE;
         end
         PH_DROGUE: begin
            if (s.altitude < main_thr) begin
               nxt = PH_MAIN;
            end else if (held_cmd == CMD_END) begin
               nxt = PH_END; w.command_consumed = 1'b1;
            end
         end
         PH_MAIN: begin
            // leaving on lost descent keeps the command pending
            if (!w.descending) begin
               nxt = PH_END;
            end else if (held_cmd == CMD_END) begin
               nxt = PH_END; w.command_consumed = 1'b1;
            end
         end
         PH_TEST: begin
            if (held_cmd == CMD_DROGUE) begin
               w.servo_pulse_us = PULSE_OPEN; nxt = PH_DROGUE; w.command_consumed = 1'b1;
            end else if (held_cmd == CMD_MAINSH) begin
               nxt = PH_MAIN; w.command_consumed = 1'b1;
            end else if (held_cmd == CMD_END) begin
               nxt = PH_END; w.command_consumed = 1'b1;
            end
         end
         default: begin
            if (held_cmd == CMD_PRE) begin
               nxt = PH_PRELAUNCH; w.command_consumed = 1'b1;
            end
         end
      endcase
      if (w.command_consumed) held_cmd = CMD_NONE;
      phase = nxt;
      w.phase = nxt;
      w.servo_update = (w.servo_pulse_us != '0);
      expected_words.push_back(w);
   endfunction

   task report_mismatch(string msg);
      $display("%t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // Compare an accepted result word with the oldest expected one
   task check_word(flight_word got);
      flight_word want;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("result word with none expected, phase %0d", got.phase));
         return;
      end
      want = expected_words.pop_front();
      if (got.phase !== want.phase)
         report_mismatch($sformatf("phase %0d, want %0d", got.phase, want.phase));
      if (got.descending !== want.descending)
         report_mismatch($sformatf("descending %b, want %b", got.descending, want.descending));
      if (got.servo_update !== want.servo_update)
         report_mismatch($sformatf("servo_update %b, want %b",
                                   got.servo_update, want.servo_update));
      if (got.servo_pulse_us !== want.servo_pulse_us)
         report_mismatch($sformatf("servo_pulse_us %0d, want %0d",
                                   got.servo_pulse_us, want.servo_pulse_us));
      if (got.command_consumed !== want.command_consumed)
         report_mismatch($sformatf("command_consumed %b, want %b",
                                   got.command_consumed, want.command_consumed));
   endtask
endclass

module flight_phase_sequencer_top_test;

   localparam logic [CMD_W-1:0]     CMD_SEVEN = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int P_MAX     = 131071;
   localparam int ALT_MIN   = -10000;
   localparam int ALT_MAX   = 1000000;
   localparam int ACCEL_MIN = -32768;
   localparam int ACCEL_MAX = 32767;
   localparam int STALL_PCT = 27;
   localparam int WATCH_LIMIT = 2000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [PRESSURE_W-1:0]       req_pressure_pa = '0;
   logic signed [ALT_W-1:0]     req_altitude_dm = '0;
   logic signed [ACCEL_W-1:0]   req_accel_z = '0;
   logic [CMD_W-1:0]            req_command = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [PHASE_W-1:0]          rsp_phase;
   logic                        rsp_descending;
   logic                        rsp_servo_update;
   logic [PULSE_W-1:0]          rsp_servo_pulse_us;
   logic                        rsp_command_consumed;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   sequencer_scoreboard sb;
   bit                  calm = 1'b0;
   int                  quiet_cycles = 0;

   flight_phase_sequencer_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pressure_pa      (req_pressure_pa),
      .req_altitude_dm      (req_altitude_dm),
      .req_accel_z          (req_accel_z),
      .req_command          (req_command),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_phase            (rsp_phase),
      .rsp_descending       (rsp_descending),
      .rsp_servo_update     (rsp_servo_update),
      .rsp_servo_pulse_us   (rsp_servo_pulse_us),
      .rsp_command_consumed (rsp_command_consumed),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   // Check result words and stall the result side at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word({rsp_phase, rsp_descending, rsp_servo_update,
                        rsp_servo_pulse_us, rsp_command_consumed});
      rsp_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCH_LIMIT) begin
         $display("flight_phase_sequencer_top_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic sample_word sample_of(int p, int alt, int az, logic [CMD_W-1:0] cmd);
      sample_word s;
      s.pressure = PRESSURE_W'(p);
      s.altitude = ALT_W'(alt);
      s.accel    = ACCEL_W'(az);
      s.command  = cmd;
      return s;
   endfunction

   // Pick a sample that fits the predicted phase, or plain noise now and then
   function automatic sample_word plan_sample();
      sample_word s;
      int         mean_p;
      int         roll;
      mean_p = sb.ring_total() / RING_DEPTH;
      if ($urandom_range(0, 99) < 20) begin
         s.pressure = PRESSURE_W'($urandom);
         s.altitude = ALT_W'(int'($urandom_range(0, ALT_MAX - ALT_MIN)) + ALT_MIN);
         s.accel    = ACCEL_W'($urandom);
         s.command  = CMD_W'($urandom_range(0, 7));
         return s;
      end
      // hover around the ring mean so descent goes both ways
      if ($urandom_range(0, 9) == 0)
         s.pressure = PRESSURE_W'($urandom);
      else
         s.pressure = PRESSURE_W'(clamp(mean_p + int'($urandom_range(0, 24)) - 12,
                                        0, P_MAX));
      if ($urandom_range(0, 3) == 0)
         s.altitude = ALT_W'(int'($urandom_range(0, ALT_MAX - ALT_MIN)) + ALT_MIN);
      else
         s.altitude = ALT_W'(clamp(int'(sb.main_thr) + int'($urandom_range(0, 6)) - 3,
                                   ALT_MIN, ALT_MAX));
      case (sb.phase)
         PH_READY: s.accel = ACCEL_W'(clamp(int'(sb.launch_thr) +
                                            int'($urandom_range(0, 6)) - 3,
                                            ACCEL_MIN, ACCEL_MAX));
         PH_POWERED: s.accel = ACCEL_W'(clamp(int'(sb.burnout_thr) +
                                              int'($urandom_range(0, 6)) - 3,
                                              ACCEL_MIN, ACCEL_MAX));
         default: s.accel = ACCEL_W'($urandom);
      endcase
      s.command = CMD_NONE;
      roll = $urandom_range(0, 99);
      case (sb.phase)
         PH_PRELAUNCH: begin
            if (roll < 25) s.command = CMD_LAUNCH;
            else if (roll < 33) s.command = CMD_TEST;
            else if (roll < 36) s.command = CMD_END;
         end
         PH_READY: begin
            if (roll < 5) s.command = CMD_PRE;
            else if (roll < 9) s.command = CMD_TEST;
            else if (roll < 12) s.command = CMD_END;
         end
         PH_DROGUE, PH_MAIN: begin
            if (roll < 15) s.command = CMD_END;
         end
         PH_TEST: begin
            if (roll < 12) s.command = CMD_DROGUE;
            else if (roll < 22) s.command = CMD_MAINSH;
            else if (roll < 28) s.command = CMD_END;
         end
         PH_END: begin
            if (roll < 40) s.command = CMD_PRE;
         end
         default: begin
            if (roll < 5) s.command = CMD_W'($urandom_range(1, 7));
         end
      endcase
      return s;
   endfunction

   // Offer one sample word and hold it until accepted
   task automatic send_sample(input sample_word s);
      if (!calm) begin
         while ($urandom_range(0, 99) < STALL_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_pressure_pa <= s.pressure;
      req_altitude_dm <= s.altitude;
      req_accel_z     <= s.accel;
      req_command     <= s.command;
      do @(posedge clock); while (req_stall);
      sb.take_sample(s);
   endtask

   task automatic run_flights(input int count);
      repeat (count) send_sample(plan_sample());
      req_valid <= 1'b0;
   endtask

   // Write one register; csr_valid stays high for the next write
   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   // Drain outstanding words, then load a new set of thresholds
   task automatic program_thresholds(input int launch, input int burnout, input int main_alt);
      while (sb.expected_words.size() != 0) @(posedge clock);
      put_reg(CSR_LAUNCH_ACCEL, {5'($urandom), 16'(launch)});
      put_reg(CSR_BURNOUT_ACCEL, {5'($urandom), 16'(burnout)});
      put_reg(CSR_MAIN_ALT, 21'(main_alt));
      put_reg(CSR_SPARE, 21'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass at reset thresholds
      send_sample(sample_of(0, ALT_MIN, ACCEL_MIN, CMD_NONE));
      send_sample(sample_of(P_MAX, ALT_MAX, ACCEL_MAX, CMD_SEVEN));
      send_sample(sample_of(P_MAX, 0, 0, CMD_NONE));
      send_sample(sample_of(1000, 0, 0, CMD_LAUNCH));
      send_sample(sample_of(1000, 0, 3000, CMD_DROGUE));
      send_sample(sample_of(1000, 0, 3001, CMD_NONE));
      send_sample(sample_of(1000, 0, 0, CMD_NONE));
      send_sample(sample_of(1000, 0, -1, CMD_NONE));
      send_sample(sample_of(0, 0, 0, CMD_NONE));
      send_sample(sample_of(P_MAX, 5000, 0, CMD_NONE));
      send_sample(sample_of(P_MAX, 2999, 0, CMD_END));
      send_sample(sample_of(P_MAX, 2999, 0, CMD_NONE));
      send_sample(sample_of(0, 0, 0, CMD_PRE));
      send_sample(sample_of(0, 0, 0, CMD_TEST));
      send_sample(sample_of(0, 0, 0, CMD_LAUNCH));
      send_sample(sample_of(P_MAX, 0, 0, CMD_MAINSH));
      send_sample(sample_of(0, 0, 0, CMD_END));
      send_sample(sample_of(0, 0, 0, CMD_PRE));
      send_sample(sample_of(0, 0, 0, CMD_END));
      send_sample(sample_of(0, 0, 0, CMD_PRE));
      send_sample(sample_of(0, 0, 0, CMD_TEST));
      send_sample(sample_of(0, 0, 0, CMD_DROGUE));
      send_sample(sample_of(0, ALT_MAX, 0, CMD_END));
      send_sample(sample_of(0, 0, 0, CMD_PRE));
      send_sample(sample_of(0, 0, 0, CMD_LAUNCH));
      send_sample(sample_of(0, 0, ACCEL_MAX, CMD_TEST));
      send_sample(sample_of(0, 0, 0, CMD_PRE));
      send_sample(sample_of(0, 0, 0, CMD_LAUNCH));
      send_sample(sample_of(0, 0, ACCEL_MAX, CMD_PRE));
      run_flights(170);

      // sweep threshold settings, extremes first
      program_thresholds(ACCEL_MIN, ACCEL_MAX, ALT_MAX);
      run_flights(190);
      program_thresholds(ACCEL_MAX, ACCEL_MIN, ALT_MIN);
      run_flights(110);
      program_thresholds(int'($urandom_range(0, 6000)) - 3000,
                         int'($urandom_range(0, 6000)) - 3000,
                         int'($urandom_range(0, 20000)) - 10000);
      calm = 1'b1;
      run_flights(220);
      calm = 1'b0;
      program_thresholds(LAUNCH_RST, BURNOUT_RST, MAIN_RST);
      run_flights(200);
      program_thresholds(int'($urandom_range(0, 800)) - 400,
                         int'($urandom_range(0, 800)) - 400,
                         int'($urandom_range(0, 1010000)) - 10000);
      run_flights(200);

      // let the last words drain and idle before the final report
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("flight_phase_sequencer_top_test: clean");
      end else begin
         $display("flight_phase_sequencer_top_test: errors");
      end
      $finish;
   end

endmodule
